### sv/dxtbd_pkg.sv
`timescale 1ns / 1ps
// Types, constants and arithmetic helpers for the DXT block decoder.
// No dependencies; imported by every module of the block.
package dxtbd_pkg;

    localparam int DXTBD_QUEUE_DEPTH = 2;

    localparam logic [1:0] FMT_DXT1   = 2'd0;
    localparam int         FMT_INTERP_BIT = 1;

    typedef struct packed {
        logic [63:0] alpha_block;
        logic [63:0] color_block;
    } t_in;

    typedef struct packed {
        logic [1:0]  row_index;
        logic [63:0] texels_left;
        logic [63:0] texels_right;
        logic        last_row;
    } t_out;

    typedef struct packed {
        logic [63:0] ablk;
        logic [63:0] cblk;
        logic        dxt1;
        logic        interp;
        logic        three;
        logic        agt;
    } t_class;

    typedef struct packed {
        logic [3:0][31:0] pal;
        logic [7:0][7:0]  acode;
        logic [15:0][1:0] cidx;
        logic [15:0][3:0] anib;
        logic [15:0][2:0] aidx;
        logic             dxt1;
        logic             interp;
    } t_entry;

    function automatic logic [7:0] expand5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] expand6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    // x <= 765
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [20:0] p;
        p = {11'd0, x} * 21'd683;
        return p[18:11];
    endfunction

    // x <= 1275
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [23:0] p;
        p = {13'd0, x} * 24'd3277;
        return p[21:14];
    endfunction

    // x <= 1785
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [23:0] p;
        p = {13'd0, x} * 24'd2341;
        return p[21:14];
    endfunction

endpackage

### sv/dxtbd_front.sv
`timescale 1ns / 1ps
// Front end: format register, block intake and classification, palette build.
// Depends on dxtbd_pkg; feeds dxtbd_queue.
module dxtbd_front
    import dxtbd_pkg::*;
#(
    parameter int QUEUE_DEPTH = DXTBD_QUEUE_DEPTH,
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_data,
    input  logic          i_start,
    input  t_in           i_block,
    input  logic [CW-1:0] i_q_count,
    output logic          o_busy,
    output logic          o_push,
    output t_entry        o_entry
);

    logic [1:0] r_format;
    logic       r_s1_vld;
    t_class     r_s1;
    t_class     n_s1;
    logic       w_accept;
    logic [CW:0] w_used;

    assign w_used   = {1'b0, i_q_count} + (CW + 1)'(r_s1_vld);
    assign o_busy   = w_used >= (CW + 1)'(QUEUE_DEPTH);
    assign w_accept = i_start && !o_busy;

    always_comb begin
        n_s1.ablk   = i_block.alpha_block;
        n_s1.cblk   = i_block.color_block;
        n_s1.dxt1   = (r_format == FMT_DXT1);
        n_s1.interp = r_format[FMT_INTERP_BIT];
        n_s1.three  = (r_format == FMT_DXT1) &&
                      (i_block.color_block[15:0] <= i_block.color_block[31:16]);
        n_s1.agt    = i_block.alpha_block[7:0] > i_block.alpha_block[15:8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_DXT1;
            r_s1_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_format <= i_cfg_data;
            end
            r_s1_vld <= w_accept;
        end
        if (w_accept) begin
            r_s1 <= n_s1;
        end
    end

    always_comb begin
        logic [2:0][7:0] c0;
        logic [2:0][7:0] c1;
        logic [2:0][7:0] m2;
        logic [2:0][7:0] m3;
        logic [7:0]      a0;
        logic [7:0]      a1;
        logic [10:0]     ws;
        c0[0] = expand5(r_s1.cblk[15:11]);
        c0[1] = expand6(r_s1.cblk[10:5]);
        c0[2] = expand5(r_s1.cblk[4:0]);
        c1[0] = expand5(r_s1.cblk[31:27]);
        c1[1] = expand6(r_s1.cblk[26:21]);
        c1[2] = expand5(r_s1.cblk[20:16]);
        for (int ch = 0; ch < 3; ch++) begin
            if (r_s1.three) begin
                m2[ch] = 8'(({1'b0, c0[ch]} + {1'b0, c1[ch]}) >> 1);
                m3[ch] = 8'd0;
            end else begin
                m2[ch] = div3({1'b0, c0[ch], 1'b0} + {2'd0, c1[ch]});
                m3[ch] = div3({2'd0, c0[ch]} + {1'b0, c1[ch], 1'b0});
            end
        end
        o_entry.pal[0] = {8'hFF, c0[2], c0[1], c0[0]};
        o_entry.pal[1] = {8'hFF, c1[2], c1[1], c1[0]};
        o_entry.pal[2] = {8'hFF, m2[2], m2[1], m2[0]};
        o_entry.pal[3] = {(r_s1.three ? 8'h00 : 8'hFF), m3[2], m3[1], m3[0]};

        a0 = r_s1.ablk[7:0];
        a1 = r_s1.ablk[15:8];
        o_entry.acode[0] = a0;
        o_entry.acode[1] = a1;
        for (int k = 1; k < 7; k++) begin
            if (r_s1.agt) begin
                ws = 11'(7 - k) * {3'd0, a0} + 11'(k) * {3'd0, a1};
                o_entry.acode[k + 1] = div7(ws);
            end else if (k < 5) begin
                ws = 11'(5 - k) * {3'd0, a0} + 11'(k) * {3'd0, a1};
                o_entry.acode[k + 1] = div5(ws);
            end else begin
                ws = 11'd0;
                o_entry.acode[k + 1] = (k == 5) ? 8'h00 : 8'hFF;
            end
        end

        o_entry.cidx   = r_s1.cblk[63:32];
        o_entry.anib   = r_s1.ablk;
        o_entry.aidx   = r_s1.ablk[63:16];
        o_entry.dxt1   = r_s1.dxt1;
        o_entry.interp = r_s1.interp;
    end

    assign o_push = r_s1_vld;

endmodule

### sv/dxtbd_queue.sv
`timescale 1ns / 1ps
// Short queue of decoded block palettes between front and back end.
// Depends on dxtbd_pkg for the entry type.
module dxtbd_queue
    import dxtbd_pkg::*;
#(
    parameter int QUEUE_DEPTH = DXTBD_QUEUE_DEPTH,
    localparam int CW = $clog2(QUEUE_DEPTH + 1),
    localparam int PW = $clog2(QUEUE_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_entry        i_entry,
    input  logic          i_pop,
    output t_entry        o_head,
    output logic          o_valid,
    output logic [CW-1:0] o_count
);

    t_entry        r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_count = r_count;

endmodule

### sv/dxtbd_back.sv
`timescale 1ns / 1ps
// Back end: emits the four texel rows of the head block, one row per cycle while the queue holds a block.
// Depends on dxtbd_pkg; reads dxtbd_queue.
module dxtbd_back
    import dxtbd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_entry i_entry,
    output logic   o_pop,
    output logic   o_strobe,
    output t_out   o_result
);

    logic [1:0] r_row;
    logic       r_strobe;
    t_out       r_result;
    t_out       n_result;

    always_comb begin
        logic [3:0][31:0] tex;
        logic [3:0]       ti;
        logic [31:0]      t;
        logic [7:0]       a;
        for (int col = 0; col < 4; col++) begin
            ti = {r_row, 2'(col)};
            t  = i_entry.pal[i_entry.cidx[ti]];
            a  = i_entry.interp ? i_entry.acode[i_entry.aidx[ti]]
                                : {i_entry.anib[ti], i_entry.anib[ti]};
            tex[col] = i_entry.dxt1 ? t : {a, t[23:0]};
        end
        n_result.row_index    = r_row;
        n_result.texels_left  = {tex[1], tex[0]};
        n_result.texels_right = {tex[3], tex[2]};
        n_result.last_row     = (r_row == 2'd3);
    end

    assign o_pop = i_valid && (r_row == 2'd3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= 2'd0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_valid;
            if (i_valid) begin
                r_row <= r_row + 2'd1;
            end
        end
        if (i_valid) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

### sv/dxt_block_decoder_unit.sv
`timescale 1ns / 1ps
// DXT1/DXT3/DXT5 block decoder top: front end, palette queue, row emitter.
// Order: the first row strobes once the block has passed the stage-1 register, the queue and the
// row output register; rows follow back to back, one row per cycle while the queue holds a block.
// Reset: format returns to DXT1, queue and row counter empty; results cannot be stalled.
// Depends on dxtbd_pkg, dxtbd_front, dxtbd_queue, dxtbd_back.
module dxt_block_decoder_unit
    import dxtbd_pkg::*;
#(
    parameter int QUEUE_DEPTH = DXTBD_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_data,
    input  logic       start,
    output logic       busy,
    input  t_in        i_block,
    output logic       strobe,
    output t_out       o_row
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic          w_push;
    t_entry        w_push_entry;
    logic          w_pop;
    t_entry        w_head;
    logic          w_head_vld;
    logic [CW-1:0] w_count;

    dxtbd_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_start    (start),
        .i_block    (i_block),
        .i_q_count  (w_count),
        .o_busy     (busy),
        .o_push     (w_push),
        .o_entry    (w_push_entry)
    );

    dxtbd_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_valid (w_head_vld),
        .o_count (w_count)
    );

    dxtbd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_head_vld),
        .i_entry  (w_head),
        .o_pop    (w_pop),
        .o_strobe (strobe),
        .o_result (o_row)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_pop |-> w_count < CW'(QUEUE_DEPTH))
        else $error("queue written while full");

    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        strobe && o_row.row_index != 2'd0 |->
            $past(strobe) && ($past(o_row.row_index) + 2'd1 == o_row.row_index))
        else $error("row emitted out of order");

    a_block_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        strobe && o_row.row_index == 2'd3 |=> !strobe || o_row.row_index == 2'd0)
        else $error("row sequence not restarted after last row");

endmodule
